FILE: src/tgarle_pkg.sv
// Shared types, register map and constants for the TGA RLE pixel decoder.
package tgarle_pkg;

  localparam int unsigned CountW = 30;
  localparam int unsigned AddrW  = 4;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_RLE_MODE  = 2'd0;
  localparam logic [1:0] REG_BPP       = 2'd1;
  localparam logic [1:0] REG_PIX_COUNT = 2'd2;

  localparam logic [2:0] BPP_RESET = 3'd3;
  localparam logic [2:0] BPP_MIN   = 3'd2;
  localparam logic [2:0] BPP_MID   = 3'd3;
  localparam logic [2:0] BPP_MAX   = 3'd4;

  // 1-5-5-5 unpacking masks
  localparam logic [7:0] MASK_RED_HI   = 8'h7c;
  localparam logic [7:0] MASK_GREEN_HI = 8'h03;
  localparam logic [7:0] MASK_GREEN_LO = 8'he0;
  localparam logic [7:0] MASK_BLUE     = 8'h1f;
  localparam logic [7:0] MASK_ALPHA    = 8'h80;
  localparam logic [7:0] MASK_COUNT    = 8'h7f;

  typedef struct packed {
    logic              rle_mode;
    logic [2:0]        bytes_per_pixel;
    logic [CountW-1:0] pixel_count;
  } cfg_t;

  typedef struct packed {
    logic       last_pixel;
    logic [7:0] repeat_res;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } result_t;

endpackage

FILE: src/tgarle_cfg_regs.sv
// APB register file holding mode, pixel size and pixel count.
module tgarle_cfg_regs
  import tgarle_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_RLE_MODE:  cfg_nxt.rle_mode        = pwdata[0];
        REG_BPP:       cfg_nxt.bytes_per_pixel = pwdata[2:0];
        REG_PIX_COUNT: cfg_nxt.pixel_count     = pwdata[CountW-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rle_mode        <= 1'b0;
      cfg_r.bytes_per_pixel <= BPP_RESET;
      cfg_r.pixel_count     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RLE_MODE:  prdata = {31'd0, cfg_r.rle_mode};
      REG_BPP:       prdata = {29'd0, cfg_r.bytes_per_pixel};
      REG_PIX_COUNT: prdata = {{(32-CountW){1'b0}}, cfg_r.pixel_count};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: src/tgarle_decode.sv
// Per-byte decode: pixel assembly, packet header tracking and color expansion.
module tgarle_decode
  import tgarle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       byte_en,
  input  logic [7:0] data_byte,
  input  logic       image_start,
  output logic       res_valid,
  output result_t    res
);

  logic [23:0]       held_r, held_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic              await_r, await_nxt;
  logic              run_r, run_nxt;
  logic [6:0]        run_cnt_r, run_cnt_nxt;
  logic [6:0]        raw_left_r, raw_left_nxt;
  logic [CountW-1:0] left_r, left_nxt;

  logic [23:0]       held_s;
  logic [1:0]        pos_s;
  logic              await_s;
  logic [CountW-1:0] left_s;
  logic [2:0]        size;
  logic [7:0]        p0, p1, p2;
  logic [7:0]        rep, rep_clip;
  logic [CountW-1:0] left_after;

  always_comb begin
    if (cfg.bytes_per_pixel < BPP_MIN)      size = BPP_MIN;
    else if (cfg.bytes_per_pixel > BPP_MAX) size = BPP_MAX;
    else                                    size = cfg.bytes_per_pixel;
  end

  // Image start restarts counters before the byte itself is decoded
  assign held_s  = image_start ? 24'd0 : held_r;
  assign pos_s   = image_start ? 2'd0 : pos_r;
  assign await_s = image_start ? 1'b1 : await_r;
  assign left_s  = image_start ? cfg.pixel_count : left_r;

  assign p0 = held_s[7:0];
  assign p1 = (size == BPP_MIN) ? data_byte : held_s[15:8];
  assign p2 = (size == BPP_MID) ? data_byte : held_s[23:16];

  assign rep = (cfg.rle_mode && run_r) ? ({1'b0, run_cnt_r} + 8'd1) : 8'd1;
  assign rep_clip   = ({{(CountW-8){1'b0}}, rep} > left_s) ? left_s[7:0] : rep;
  assign left_after = left_s - {{(CountW-8){1'b0}}, rep_clip};

  always_comb begin
    held_nxt     = held_s;
    pos_nxt      = pos_s;
    await_nxt    = await_s;
    run_nxt      = run_r;
    run_cnt_nxt  = run_cnt_r;
    raw_left_nxt = raw_left_r;
    left_nxt     = left_s;
    res_valid    = 1'b0;

    if (size == BPP_MIN) begin
      res.red   = (p1 & MASK_RED_HI) << 1;
      res.green = ((p1 & MASK_GREEN_HI) << 6) | ((p0 & MASK_GREEN_LO) >> 2);
      res.blue  = (p0 & MASK_BLUE) << 3;
      res.alpha = p1 & MASK_ALPHA;
    end else begin
      res.red   = p2;
      res.green = p1;
      res.blue  = p0;
      res.alpha = (size == BPP_MAX) ? data_byte : 8'd0;
    end
    res.repeat_res = rep_clip;
    res.last_pixel = (left_after == '0);

    if (left_s == '0) begin
      // idle: drop the byte
    end else if (cfg.rle_mode && await_s) begin
      run_nxt      = data_byte[7];
      run_cnt_nxt  = data_byte[6:0];
      raw_left_nxt = data_byte[6:0];
      await_nxt    = 1'b0;
      pos_nxt      = 2'd0;
    end else if (({1'b0, pos_s} + 3'd1) < size) begin
      unique case (pos_s)
        2'd0:    held_nxt[7:0]   = data_byte;
        2'd1:    held_nxt[15:8]  = data_byte;
        2'd2:    held_nxt[23:16] = data_byte;
        default: held_nxt        = held_s;
      endcase
      pos_nxt = pos_s + 2'd1;
    end else begin
      res_valid = 1'b1;
      pos_nxt   = 2'd0;
      if (cfg.rle_mode) begin
        if (run_r)                   await_nxt    = 1'b1;
        else if (raw_left_r == 7'd0) await_nxt    = 1'b1;
        else                         raw_left_nxt = raw_left_r - 7'd1;
      end
      left_nxt = left_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      pos_r      <= '0;
      await_r    <= 1'b1;
      run_r      <= 1'b0;
      run_cnt_r  <= '0;
      raw_left_r <= '0;
      left_r     <= '0;
    end else if (byte_en) begin
      held_r     <= held_nxt;
      pos_r      <= pos_nxt;
      await_r    <= await_nxt;
      run_r      <= run_nxt;
      run_cnt_r  <= run_cnt_nxt;
      raw_left_r <= raw_left_nxt;
      left_r     <= left_nxt;
    end
  end

endmodule

FILE: src/tgarle_out_buf.sv
// Result register with a skid stage so the input side keeps flowing.
module tgarle_out_buf
  import tgarle_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_accept,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t main_r, skid_r;
  logic    main_v_r, skid_v_r;
  logic    pop;

  assign can_accept = ~skid_v_r;
  assign pop        = main_v_r & out_ready;
  assign out_valid  = main_v_r;
  assign out_data   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      if (!main_v_r) main_v_r <= 1'b1;
      else           skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v_r) main_r <= skid_r;
      else if (push) main_r <= push_data;
    end else if (push) begin
      if (!main_v_r) main_r <= push_data;
      else           skid_r <= push_data;
    end
  end

endmodule

FILE: src/tga_rle_pixel_decoder_unit.sv
// Top level of the TGA pixel-data decoder: stream in bytes, stream out pixels.
//
// The input stream carries one byte of the TGA pixel-data section per
// transaction; in_tuser marks the first byte of an image and reloads all
// counters. The output stream carries one transaction per decoded pixel:
// red, green, blue, alpha and a repeat count, with out_tlast on the pixel
// that completes the image. Mode, bytes per pixel and pixel count are set
// over the APB port, by the user only while the block is idle; the block
// does not enforce it. One byte is accepted every cycle in_tready is high.
// A pixel is registered on the transaction of its final byte; the byte
// update is a single combinational step from state to result register.
// A two-entry output buffer (result register plus skid) lets a byte be taken
// while a result waits; in_tready drops only when both entries are full.
// Reset clears the decode state, empties the output buffer and loads the
// registers with uncompressed mode, 3 bytes per pixel and a count of zero;
// bytes are then ignored until an image start.
module tga_rle_pixel_decoder_unit
  import tgarle_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // data_byte[7:0]
  input  logic             in_tuser,   // image_start
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,  // red, green, blue, alpha, repeat_res
  output logic             out_tlast,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg;
  logic    byte_en;
  logic    res_valid;
  result_t res, out_res;

  tgarle_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign byte_en = in_tvalid & in_tready;

  tgarle_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .byte_en     (byte_en),
    .data_byte   (in_tdata),
    .image_start (in_tuser),
    .res_valid   (res_valid),
    .res         (res)
  );

  tgarle_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (byte_en & res_valid),
    .push_data  (res),
    .can_accept (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {out_res.repeat_res, out_res.alpha, out_res.blue,
                      out_res.green, out_res.red};
  assign out_tlast = out_res.last_pixel;

endmodule
